// File: design/kll_quantile_sketch_core_assert.svh
// Assertion helpers for kll_quantile_sketch_core; clk and rst come from the enclosing module.
`ifndef KLL_QUANTILE_SKETCH_CORE_ASSERT_SVH
`define KLL_QUANTILE_SKETCH_CORE_ASSERT_SVH

// cond must never hold outside reset
`define KQS_NEVER(name, cond, msg) \
  name: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error(msg);

// same-cycle implication
`define KQS_IMPLY(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KQS_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/kqs_pkg.sv
package kqs_pkg;

  localparam int K_DEF           = 64;
  localparam int CAP_NUM_DEF     = 2;
  localparam int CAP_DEN_DEF     = 3;
  localparam int MAX_LEVELS_DEF  = 16;
  localparam int LEVEL_SLOTS_DEF = 256;

  localparam int CAP_LIMIT = 65535;
  localparam int RANK_W    = 49;
  localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;
  localparam logic [16:0] Q_ONE     = 17'd65536;

  // request opcodes
  localparam logic OP_ADD = 1'b0;
  localparam logic OP_QRY = 1'b1;

  // exact max(2, ceil(k * (cn/cd)^d)), saturating; elaboration only
  function automatic logic [15:0] cap_calc(int k, int cn, int cd, int d);
    logic [255:0] nm;
    logic [255:0] dn;
    int lo;
    int hi;
    int mid;
    logic [15:0] c;
    nm = 256'(k);
    dn = 256'd1;
    for (int x = 0; x < d; x++) begin
      nm = nm * 256'(cn);
      dn = dn * 256'(cd);
    end
    if (dn * 256'(CAP_LIMIT) < nm) begin
      c = 16'(CAP_LIMIT);
    end else begin
      lo = 1;
      hi = CAP_LIMIT;
      while (lo < hi) begin
        mid = lo + ((hi - lo) >> 1);
        if (dn * 256'(mid) >= nm) hi = mid;
        else lo = mid + 1;
      end
      c = 16'(lo);
    end
    if (c < 16'd2) c = 16'd2;
    return c;
  endfunction

  // sum of capacities over l levels
  function automatic logic [31:0] cap_sum_calc(int k, int cn, int cd, int l);
    logic [31:0] s;
    s = '0;
    for (int d = 0; d < l; d++) begin
      s = s + 32'(cap_calc(k, cn, cd, d));
    end
    return s;
  endfunction

endpackage

// File: design/kll_quantile_sketch_core.sv
// KLL quantile sketch over signed Q16.16 samples. op 0 adds value, op 1 asks for the
// quantile (unsigned 1.16, 65536 = one); each request gives one result carrying the
// answer and the sketch status. A compaction of a level is a selection sort through the
// single read port of the level memory. A query makes up to 33 passes over all stored
// items (one for weight and maximum, then one per answer bit of a binary search).
// in_stall is high while a request is in work. The memory needs no clearing pass.
`include "kll_quantile_sketch_core_assert.svh"

module kll_quantile_sketch_core import kqs_pkg::*; #(
  parameter int K           = K_DEF,
  parameter int CAP_NUM     = CAP_NUM_DEF,
  parameter int CAP_DEN     = CAP_DEN_DEF,
  parameter int MAX_LEVELS  = MAX_LEVELS_DEF,
  parameter int LEVEL_SLOTS = LEVEL_SLOTS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               op,
  input  logic signed [31:0] value,
  input  logic [16:0]        quantile,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] answer_value,
  output logic               answer_valid,
  output logic [31:0]        items_seen,
  output logic [12:0]        items_stored,
  output logic [4:0]         levels_in_use,
  output logic               overflowed,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [31:0]        cfg_data
);

  localparam int SIW   = $clog2(LEVEL_SLOTS);
  localparam int LIW   = $clog2(MAX_LEVELS);
  localparam int FW    = $clog2(LEVEL_SLOTS + 1);
  localparam int LW    = $clog2(MAX_LEVELS + 1);
  localparam int AW    = LIW + SIW;
  localparam int DEPTH = MAX_LEVELS * (2 ** SIW);
  localparam int TW    = $clog2(MAX_LEVELS * LEVEL_SLOTS + 1);
  localparam int CSW   = $clog2(MAX_LEVELS * CAP_LIMIT + 1);
  localparam int ACCW  = FW + MAX_LEVELS;
  localparam int CW    = (ACCW + 16 > RANK_W) ? ACCW + 16 : RANK_W;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_ADD    = 4'd1;
  localparam logic [3:0] S_FIND   = 4'd2;
  localparam logic [3:0] S_COIN   = 4'd3;
  localparam logic [3:0] S_SCAN   = 4'd4;
  localparam logic [3:0] S_SWAP   = 4'd5;
  localparam logic [3:0] S_PROMO  = 4'd6;
  localparam logic [3:0] S_QSETUP = 4'd7;
  localparam logic [3:0] S_QSCAN  = 4'd8;
  localparam logic [3:0] S_QEVAL  = 4'd9;
  localparam logic [3:0] S_DONE   = 4'd10;

  logic [15:0]    cap_tab    [MAX_LEVELS];
  logic [CSW-1:0] capsum_tab [MAX_LEVELS];

  for (genvar g = 0; g < MAX_LEVELS; g++) begin : g_cap
    localparam logic [15:0] CAPV = cap_calc(K, CAP_NUM, CAP_DEN, g);
    localparam logic [31:0] SUMV = cap_sum_calc(K, CAP_NUM, CAP_DEN, g + 1);
    assign cap_tab[g]    = CAPV;
    assign capsum_tab[g] = CSW'(SUMV);
  end

  logic [3:0]          state;
  logic [FW-1:0]       fill [MAX_LEVELS];
  logic [LW-1:0]       count;
  logic [31:0]         seen;
  logic [TW-1:0]       total;
  logic [31:0]         lfsr;
  logic                ovf;

  logic [16:0]         q_q;

  logic [LIW-1:0]      h;
  logic [LIW-1:0]      up;
  logic [LIW-1:0]      lev;
  logic [FW-1:0]       n;
  logic [FW-1:0]       i;
  logic [FW-1:0]       j;
  logic                off;
  logic signed [31:0]  first;
  logic signed [31:0]  minv;
  logic [SIW-1:0]      minidx;

  logic                pv;
  logic [SIW-1:0]      pidx;
  logic [LIW-1:0]      plev;

  logic                qpass;
  logic [RANK_W-1:0]   rank;
  logic [ACCW-1:0]     acc;
  logic signed [31:0]  maxv;
  logic [31:0]         res;
  logic [31:0]         bsel;
  logic signed [31:0]  ans;
  logic                ans_vld;

  logic [31:0]         mem [DEPTH];
  logic [31:0]         rd_data;
  logic [AW-1:0]       rd_addr;
  logic                issue;
  logic                we;
  logic [AW-1:0]       wa;
  logic [31:0]         wd;

  logic                accept;
  logic [LIW-1:0]      top;
  logic                full_h;
  logic [31:0]         lfsr_n;
  logic [LIW-1:0]      up_c;
  logic [FW-1:0]       upfill;
  logic [FW:0]         promo;
  logic                adv_more;
  logic [ACCW-1:0]     wgt;
  logic [31:0]         tval;
  logic                pred;
  logic [31:0]         res_n;

  assign accept    = in_valid && !in_stall;
  assign in_stall  = (state != S_IDLE);
  assign cfg_ready = (state == S_IDLE);
  assign top       = LIW'(count - 1'b1);
  assign full_h    = 16'(fill[h]) >= cap_tab[LIW'(top - h)];
  assign lfsr_n    = {1'b0, lfsr[31:1]} ^ (lfsr[0] ? LFSR_TAPS : 32'd0);
  assign up_c      = LIW'(h + 1'b1);
  assign upfill    = (LW'(up_c) < count) ? fill[up_c] : '0;
  assign promo     = (FW + 1)'(({1'b0, fill[h]} + 1'b1 - {{FW{1'b0}}, lfsr_n[0]}) >> 1);
  assign adv_more  = FW'(i + 1'b1) < n;
  assign wgt       = ACCW'(1) << plev;
  assign tval      = res | (bsel - 32'd1);
  assign pred      = CW'({acc, 16'b0}) > CW'(rank);
  assign res_n     = pred ? res : (res | bsel);

  // read port: selection pass over one level, or query sweep over all levels
  always_comb begin
    issue   = 1'b0;
    rd_addr = '0;
    if (state == S_SCAN && j < n) begin
      issue   = 1'b1;
      rd_addr = {h, j[SIW-1:0]};
    end else if (state == S_QSCAN && j < fill[lev]) begin
      issue   = 1'b1;
      rd_addr = {lev, j[SIW-1:0]};
    end
  end

  always_comb begin
    we = 1'b0;
    wa = '0;
    wd = '0;
    priority if (state == S_IDLE && accept && op == OP_ADD &&
                 fill[0] < FW'(LEVEL_SLOTS)) begin
      we = 1'b1;
      wa = {LIW'(0), fill[0][SIW-1:0]};
      wd = value;
    end else if (state == S_SWAP) begin
      we = 1'b1;
      wa = {h, minidx};
      wd = first;
    end else if (state == S_PROMO) begin
      we = 1'b1;
      wa = {up, fill[up][SIW-1:0]};
      wd = minv;
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      for (int x = 0; x < MAX_LEVELS; x++) fill[x] <= '0;
      count     <= LW'(1);
      seen      <= '0;
      total     <= '0;
      lfsr      <= 32'd1;
      ovf       <= 1'b0;
      pv        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      pv   <= issue;
      pidx <= j[SIW-1:0];
      plev <= lev;

      if (state == S_DONE && (!out_valid || !out_stall)) begin
        out_valid     <= 1'b1;
        answer_value  <= ans;
        answer_valid  <= ans_vld;
        items_seen    <= seen;
        items_stored  <= 13'(total);
        levels_in_use <= 5'(count);
        overflowed    <= ovf;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (cfg_valid && cfg_ready) begin
            lfsr <= (cfg_data != 32'd0) ? cfg_data : 32'd1;
          end
          if (accept) begin
            q_q     <= quantile;
            ans     <= '0;
            ans_vld <= 1'b0;
            if (op == OP_QRY) begin
              state <= S_QSETUP;
            end else if (fill[0] >= FW'(LEVEL_SLOTS)) begin
              ovf   <= 1'b1;
              state <= S_DONE;
            end else begin
              fill[0] <= FW'(fill[0] + 1'b1);
              total   <= TW'(total + 1'b1);
              if (seen != '1) seen <= seen + 32'd1;
              state   <= S_ADD;
            end
          end
        end
        S_ADD: begin
          h <= '0;
          if (32'(total) >= 32'(capsum_tab[top])) state <= S_FIND;
          else state <= S_DONE;
        end
        S_FIND: begin
          if (full_h) begin
            if (h == top && count >= LW'(MAX_LEVELS)) begin
              ovf   <= 1'b1;
              state <= S_DONE;
            end else begin
              state <= S_COIN;
            end
          end else if (h == top) begin
            state <= S_DONE;
          end else begin
            h <= LIW'(h + 1'b1);
          end
        end
        S_COIN: begin
          lfsr <= lfsr_n;
          off  <= lfsr_n[0];
          if ((FW + 1)'({1'b0, upfill} + promo) > (FW + 1)'(LEVEL_SLOTS)) begin
            ovf   <= 1'b1;
            state <= S_DONE;
          end else begin
            if (h == top) begin
              fill[up_c] <= '0;
              count      <= LW'(count + 1'b1);
            end
            up    <= up_c;
            n     <= fill[h];
            i     <= '0;
            j     <= '0;
            state <= S_SCAN;
          end
        end
        // one pass finds the minimum of positions i..n-1
        S_SCAN: begin
          if (issue) j <= FW'(j + 1'b1);
          if (pv) begin
            if (pidx == i[SIW-1:0]) begin
              first  <= rd_data;
              minv   <= rd_data;
              minidx <= pidx;
            end else if ($signed(rd_data) < minv) begin
              minv   <= rd_data;
              minidx <= pidx;
            end
          end
          if (!issue && !pv) state <= S_SWAP;
        end
        S_SWAP: begin
          if (i[0] == off) begin
            state <= S_PROMO;
          end else if (adv_more) begin
            i     <= FW'(i + 1'b1);
            j     <= FW'(i + 1'b1);
            state <= S_SCAN;
          end else begin
            fill[h] <= '0;
            total   <= TW'(total - n);
            state   <= S_DONE;
          end
        end
        S_PROMO: begin
          fill[up] <= FW'(fill[up] + 1'b1);
          if (adv_more) begin
            total <= TW'(total + 1'b1);
            i     <= FW'(i + 1'b1);
            j     <= FW'(i + 1'b1);
            state <= S_SCAN;
          end else begin
            fill[h] <= '0;
            total   <= TW'(total + 1'b1 - n);
            state   <= S_DONE;
          end
        end
        S_QSETUP: begin
          rank  <= RANK_W'(q_q) * RANK_W'(seen - 32'd1);
          qpass <= 1'b0;
          acc   <= '0;
          maxv  <= 32'sh8000_0000;
          lev   <= '0;
          j     <= '0;
          if (q_q <= Q_ONE && seen != 32'd0 && total != '0) state <= S_QSCAN;
          else state <= S_DONE;
        end
        S_QSCAN: begin
          if (issue) begin
            j <= FW'(j + 1'b1);
          end else if (lev != top) begin
            lev <= LIW'(lev + 1'b1);
            j   <= '0;
          end else if (!pv) begin
            state <= S_QEVAL;
          end
          if (pv) begin
            if (!qpass) begin
              acc <= ACCW'(acc + wgt);
              if ($signed(rd_data) > maxv) maxv <= rd_data;
            end else if ({~rd_data[31], rd_data[30:0]} <= tval) begin
              acc <= ACCW'(acc + wgt);
            end
          end
        end
        // binary search in offset binary: lowest t whose weight below or at t beats rank
        S_QEVAL: begin
          acc <= '0;
          lev <= '0;
          j   <= '0;
          if (!qpass) begin
            if (!pred) begin
              ans     <= maxv;
              ans_vld <= 1'b1;
              state   <= S_DONE;
            end else begin
              qpass <= 1'b1;
              res   <= '0;
              bsel  <= 32'h8000_0000;
              state <= S_QSCAN;
            end
          end else if (bsel[0]) begin
            ans     <= {~res_n[31], res_n[30:0]};
            ans_vld <= 1'b1;
            state   <= S_DONE;
          end else begin
            res   <= res_n;
            bsel  <= bsel >> 1;
            state <= S_QSCAN;
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `KQS_NEVER(a_level_count, (count == '0) || (count > LW'(MAX_LEVELS)), "level count out of range")
  `KQS_NEXT(a_accept_busy, accept, state != S_IDLE, "accepted request did not start")
  `KQS_IMPLY(a_scan_bound, state == S_SCAN, i < n, "selection pass beyond level fill")
  `KQS_IMPLY(a_promo_room, state == S_PROMO, fill[up] < FW'(LEVEL_SLOTS), "promotion overruns level")

endmodule

// File: tb/tb_kll_quantile_sketch_core.sv
module tb_kll_quantile_sketch_core;
  import kqs_pkg::*;

  localparam int NLEV   = MAX_LEVELS_DEF;
  localparam int NSLOT  = LEVEL_SLOTS_DEF;

  typedef struct {
    logic signed [31:0] answer_value;
    logic               answer_valid;
    logic [31:0]        items_seen;
    logic [12:0]        items_stored;
    logic [4:0]         levels_in_use;
    logic               overflowed;
  } sketch_status_t;

  typedef struct {
    int v;
    int lv;
  } ranked_t;

  typedef struct {
    logic               op;
    logic signed [31:0] value;
    logic [16:0]        quantile;
    bit                 fixed;
    logic signed [31:0] fixed_value;
    logic               fixed_valid;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               op = 1'b0;
  logic signed [31:0] value = '0;
  logic [16:0]        quantile = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] answer_value;
  logic               answer_valid;
  logic [31:0]        items_seen;
  logic [12:0]        items_stored;
  logic [4:0]         levels_in_use;
  logic               overflowed;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [31:0]        cfg_data = '0;

  kll_quantile_sketch_core uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .op(op), .value(value), .quantile(quantile),
    .out_valid(out_valid), .out_stall(out_stall),
    .answer_value(answer_value), .answer_valid(answer_valid),
    .items_seen(items_seen), .items_stored(items_stored),
    .levels_in_use(levels_in_use), .overflowed(overflowed),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // shadow sketch state
  int          sk_store [NLEV][NSLOT];
  int unsigned sk_fill [NLEV];
  int unsigned sk_caps [NLEV];
  int unsigned sk_levels;
  int unsigned sk_seen;
  logic [31:0] sk_lfsr;
  bit          sk_ovf;
  ranked_t     sort_buf [NLEV*NSLOT];

  sketch_status_t pending_answers[$];
  int errors = 0;
  int n_adds = 0;
  int n_queries = 0;
  int n_found = 0;
  int max_levels = 1;
  int burst_left = 0;

  function automatic void build_level_caps();
    longint unsigned num;
    longint unsigned den;
    longint unsigned c;
    num = 64'(K_DEF);
    den = 1;
    for (int d = 0; d < NLEV; d++) begin
      c = (num + den - 1) / den;
      if (c > CAP_LIMIT) c = CAP_LIMIT;
      sk_caps[d] = (c < 2) ? 2 : int'(c);
      num = num * CAP_NUM_DEF;
      den = den * CAP_DEN_DEF;
    end
  endfunction

  function automatic int unsigned stored_sum();
    int unsigned s;
    s = 0;
    for (int h = 0; h < sk_levels; h++) s += sk_fill[h];
    return s;
  endfunction

  function automatic int unsigned capacity_sum();
    int unsigned s;
    s = 0;
    for (int d = 0; d < sk_levels; d++) s += sk_caps[d];
    return s;
  endfunction

  function automatic bit coin_flip();
    sk_lfsr = (sk_lfsr >> 1) ^ (sk_lfsr[0] ? LFSR_TAPS : 32'd0);
    return sk_lfsr[0];
  endfunction

  // stable insertion sort by value
  function automatic void sort_ranked(int n);
    ranked_t t;
    int j;
    for (int i = 1; i < n; i++) begin
      t = sort_buf[i];
      j = i - 1;
      while (j >= 0 && t.v < sort_buf[j].v) begin
        sort_buf[j+1] = sort_buf[j];
        j--;
      end
      sort_buf[j+1] = t;
    end
  endfunction

  function automatic void compact_level();
    int unsigned top;
    int unsigned fill;
    int unsigned promo;
    int unsigned up;
    int unsigned up_fill;
    bit off;
    top = sk_levels - 1;
    for (int unsigned h = 0; h < sk_levels; h++) begin
      if (sk_fill[h] < sk_caps[top - h]) continue;
      if (h == top && sk_levels >= NLEV) begin
        sk_ovf = 1'b1;
        return;
      end
      fill = sk_fill[h];
      off = coin_flip();
      promo = (fill + 1 - off) >> 1;
      up = h + 1;
      up_fill = (up < sk_levels) ? sk_fill[up] : 0;
      if (up_fill + promo > NSLOT) begin
        sk_ovf = 1'b1;
        return;
      end
      if (h == top) begin
        sk_fill[up] = 0;
        sk_levels++;
      end
      for (int i = 0; i < fill; i++) begin
        sort_buf[i].v = sk_store[h][i];
        sort_buf[i].lv = h;
      end
      sort_ranked(fill);
      for (int unsigned i = off; i < fill; i += 2) begin
        sk_store[up][sk_fill[up]] = sort_buf[i].v;
        sk_fill[up]++;
      end
      sk_fill[h] = 0;
      return;
    end
  endfunction

  function automatic sketch_status_t sketch_predict(logic o, logic signed [31:0] v,
                                                    logic [16:0] q);
    sketch_status_t r;
    int n;
    longint unsigned rank;
    longint unsigned run;
    r.answer_value = '0;
    r.answer_valid = 1'b0;
    if (o == OP_ADD) begin
      if (sk_fill[0] >= NSLOT) begin
        sk_ovf = 1'b1;
      end else begin
        sk_store[0][sk_fill[0]] = v;
        sk_fill[0]++;
        if (sk_seen != 32'hFFFF_FFFF) sk_seen++;
        if (stored_sum() >= capacity_sum()) compact_level();
      end
    end else begin
      n = 0;
      for (int h = 0; h < sk_levels; h++) begin
        for (int i = 0; i < sk_fill[h]; i++) begin
          sort_buf[n].v = sk_store[h][i];
          sort_buf[n].lv = h;
          n++;
        end
      end
      if (q <= Q_ONE && sk_seen != 0 && n != 0) begin
        sort_ranked(n);
        rank = 64'(q) * 64'(sk_seen - 1);
        run = 0;
        r.answer_value = sort_buf[n-1].v;
        for (int i = 0; i < n; i++) begin
          run += 64'd1 << sort_buf[i].lv;
          if ((run << 16) > rank) begin
            r.answer_value = sort_buf[i].v;
            break;
          end
        end
        r.answer_valid = 1'b1;
      end
    end
    r.items_seen    = sk_seen;
    r.items_stored  = 13'(stored_sum());
    r.levels_in_use = 5'(sk_levels);
    r.overflowed    = sk_ovf;
    return r;
  endfunction

  task automatic send_request(stim_row_t row);
    sketch_status_t e;
    in_valid <= 1'b1;
    op       <= row.op;
    value    <= row.value;
    quantile <= row.quantile;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    e = sketch_predict(row.op, row.value, row.quantile);
    if (row.fixed) begin
      e.answer_value = row.fixed_value;
      e.answer_valid = row.fixed_valid;
    end
    pending_answers = {pending_answers, e};
    if (row.op == OP_ADD) n_adds++;
    else n_queries++;
    if (e.answer_valid) n_found++;
    if (sk_levels > max_levels) max_levels = sk_levels;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic load_seed(logic [31:0] seed);
    in_valid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= seed;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sk_lfsr = (seed != 0) ? seed : 32'd1;
  endtask

  function automatic stim_row_t random_row();
    stim_row_t r;
    int pick;
    r.fixed = 1'b0;
    r.fixed_value = '0;
    r.fixed_valid = 1'b0;
    r.op = ($urandom_range(0, 9) == 0) ? OP_QRY : OP_ADD;
    pick = $urandom_range(0, 9);
    if (pick < 4) r.value = $urandom;
    else if (pick < 8) r.value = $signed(32'($urandom_range(0, 400))) - 200;
    else r.value = {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
    pick = $urandom_range(0, 9);
    if (pick == 0) r.quantile = 17'($urandom);
    else if (pick == 1) r.quantile = Q_ONE;
    else if (pick == 2) r.quantile = '0;
    else r.quantile = 17'($urandom_range(0, 65536));
    return r;
  endfunction

  // receiver: quiet, choppy and fully stalled spans
  int rx_mode = 0;
  int rx_left = 0;
  always @(posedge clk) begin
    if (rx_left == 0) begin
      rx_mode <= $urandom_range(0, 2);
      rx_left <= $urandom_range(50, 400);
    end else begin
      rx_left <= rx_left - 1;
    end
    case (rx_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 2) == 0);
      default: out_stall <= 1'b1;
    endcase
  end

  always @(posedge clk) begin
    sketch_status_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_answers.size() == 0) begin
        $display("%0t: result with no request pending", $time);
        errors++;
      end else begin
        e = pending_answers.pop_front();
        if (answer_value !== e.answer_value) begin
          $display("%0t: answer_value exp %h got %h", $time, e.answer_value, answer_value);
          errors++;
        end
        if (answer_valid !== e.answer_valid) begin
          $display("%0t: answer_valid exp %b got %b", $time, e.answer_valid, answer_valid);
          errors++;
        end
        if (items_seen !== e.items_seen) begin
          $display("%0t: items_seen exp %0d got %0d", $time, e.items_seen, items_seen);
          errors++;
        end
        if (items_stored !== e.items_stored) begin
          $display("%0t: items_stored exp %0d got %0d", $time, e.items_stored,
                   items_stored);
          errors++;
        end
        if (levels_in_use !== e.levels_in_use) begin
          $display("%0t: levels_in_use exp %0d got %0d", $time, e.levels_in_use,
                   levels_in_use);
          errors++;
        end
        if (overflowed !== e.overflowed) begin
          $display("%0t: overflowed exp %b got %b", $time, e.overflowed, overflowed);
          errors++;
        end
      end
    end
  end

  initial begin
    #500_000_000;
    $display("timeout with %0d results outstanding", pending_answers.size());
    $display("tb_kll_quantile_sketch_core failed");
    $finish;
  end

  stim_row_t directed [$];
  logic [31:0] seeds [3];

  initial begin
    build_level_caps();
    for (int h = 0; h < NLEV; h++) sk_fill[h] = 0;
    sk_levels = 1;
    sk_seen = 0;
    sk_lfsr = 32'd1;
    sk_ovf = 1'b0;

    // empty sketch queries, extremes, out-of-range fractions
    directed = '{
      '{OP_QRY, 32'sd0,           17'd0,       1'b1, 32'sd0, 1'b0},
      '{OP_QRY, 32'sd0,           17'd65536,   1'b1, 32'sd0, 1'b0},
      '{OP_ADD, 32'sh7FFF_FFFF,   17'd0,       1'b1, 32'sd0, 1'b0},
      '{OP_ADD, 32'sh8000_0000,   17'h1FFFF,   1'b1, 32'sd0, 1'b0},
      '{OP_ADD, 32'sd0,           17'd0,       1'b1, 32'sd0, 1'b0},
      '{OP_ADD, -32'sd1,          17'd0,       1'b1, 32'sd0, 1'b0},
      '{OP_ADD, 32'sd65536,       17'd0,       1'b1, 32'sd0, 1'b0},
      '{OP_QRY, 32'sd0,           17'd0,       1'b1, 32'sh8000_0000, 1'b1},
      '{OP_QRY, 32'sd0,           17'd65536,   1'b1, 32'sh7FFF_FFFF, 1'b1},
      '{OP_QRY, 32'sd0,           17'd32768,   1'b0, 32'sd0, 1'b0},
      '{OP_QRY, 32'sd0,           17'd65537,   1'b1, 32'sd0, 1'b0},
      '{OP_QRY, -32'sd1,          17'h1FFFF,   1'b1, 32'sd0, 1'b0},
      '{OP_ADD, 32'sh7FFF_FFFF,   17'd0,       1'b1, 32'sd0, 1'b0},
      '{OP_QRY, 32'sd0,           17'd1,       1'b0, 32'sd0, 1'b0}
    };
    seeds[0] = 32'hFFFF_FFFF;
    seeds[1] = 32'd1;
    seeds[2] = $urandom | 32'd1;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (int p = 0; p < 3; p++) begin
      load_seed(seeds[p]);
      if (p == 0) begin
        foreach (directed[i]) send_request(directed[i]);
      end
      for (int i = 0; i < 280; i++) send_request(random_row());
    end
    in_valid <= 1'b0;

    while (pending_answers.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("covered %0d adds and %0d queries (%0d answered) over 3 seeds,",
             n_adds, n_queries, n_found);
    $display("sketch grew to %0d levels, overflow flag %b", max_levels, sk_ovf);
    if (errors == 0) begin
      $display("tb_kll_quantile_sketch_core passed");
    end else begin
      $display("tb_kll_quantile_sketch_core failed");
    end
    $finish;
  end

endmodule
